// File: rtl/irpd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irpd_pkg: shared constants, types and the timing match for the IR decoder
// Holds the frame timing targets, register map codes and sequencer states.
// ----------------------------------------------------------------------------
package irpd_pkg;

  // Storage depth default
  localparam int unsigned PULSE_DEPTH_DEF = 128;

  // Field and register widths
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned PULSE_W = 16;
  localparam int unsigned TOL_W   = 10;
  localparam int unsigned GAP_W   = 16;
  localparam int unsigned MINP_W  = 16;
  localparam int unsigned TGT_W   = 14;
  localparam int unsigned FRAME_W = 32;
  localparam int unsigned PADDR_W = 4;
  localparam int unsigned PDATA_W = 32;

  // Register reset values
  localparam logic [TOL_W-1:0]  TOL_RST  = 10'd300;
  localparam logic [GAP_W-1:0]  GAP_RST  = 16'd15000;
  localparam logic [MINP_W-1:0] MINP_RST = 16'd100;

  // Register map, indexed by paddr[3:2]
  localparam logic [1:0] REG_TOL  = 2'd0;
  localparam logic [1:0] REG_GAP  = 2'd1;
  localparam logic [1:0] REG_MINP = 2'd2;

  // Frame timing in microseconds
  localparam logic [TGT_W-1:0] HDR_MARK_US   = 14'd9000;
  localparam logic [TGT_W-1:0] HDR_SPACE_US  = 14'd4500;
  localparam logic [TGT_W-1:0] BIT_MARK_US   = 14'd560;
  localparam logic [TGT_W-1:0] BIT1_SPACE_US = 14'd1690;

  localparam int unsigned MIN_INTERVALS = 66;
  localparam int unsigned FRAME_BITS    = 32;
  localparam int unsigned ENT_W         = $clog2(2 * FRAME_BITS);
  localparam int unsigned BYTE_MASK     = 8'hFF;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_EDGE = 4'b0010,
    ST_HDR  = 4'b0100,
    ST_BITS = 4'b1000
  } irpd_state_t;

  // Interval within plus or minus tol of target
  function automatic logic near_fn(input logic [PULSE_W-1:0] v,
                                   input logic [TGT_W-1:0]   tgt,
                                   input logic [TOL_W-1:0]   tol);
    logic [PULSE_W:0] lo_sum;
    logic [PULSE_W:0] hi_sum;
    lo_sum = {1'b0, v} + {{(PULSE_W + 1 - TOL_W){1'b0}}, tol};
    hi_sum = {{(PULSE_W + 1 - TGT_W){1'b0}}, tgt} + {{(PULSE_W + 1 - TOL_W){1'b0}}, tol};
    near_fn = (lo_sum >= {{(PULSE_W + 1 - TGT_W){1'b0}}, tgt}) && ({1'b0, v} <= hi_sum);
  endfunction

endpackage

// File: rtl/ir_pulse_distance_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ir_pulse_distance_decoder: pulse-distance infrared frame decoder
// Measures edge intervals into a pulse store and decodes a 32-bit frame
// (header word, command byte, check byte) on request.
// ----------------------------------------------------------------------------
//
//  channel  | handshake                 | word
//  ---------+---------------------------+--------------------------------------
//  input    | start / busy              | in_req_type, in_edge_time_us
//  result   | out_valid (1-cycle pulse) | out_frame_found, out_header_word,
//           |                           | out_command_byte, out_check_byte
//  config   | psel/penable/pwrite/pready| paddr, pwdata, prdata
//
//  Flow: an edge word passes the interval subtract, then classify and store.
//  A poll with fewer than 66 held intervals answers in the next cycle;
//  otherwise the scan streams one stored interval per cycle through the single
//  memory read port, and the poll answers once a frame decodes, a match fails
//  or the scan runs past the last held interval. busy is high while the
//  sequencer is away from idle.
//  Reset: synchronous, active low; clears the count, the last edge time, the
//  registers and the sequencer. The store itself is not cleared.
//  Stalls: the receiver cannot stall; each result is shown for one cycle.
//
module ir_pulse_distance_decoder #(
  parameter int unsigned PULSE_DEPTH = irpd_pkg::PULSE_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // input word
  input  logic                          start,
  output logic                          busy,
  input  logic                          in_req_type,
  input  logic [irpd_pkg::TIME_W-1:0]   in_edge_time_us,
  // result word
  output logic                          out_valid,
  output logic                          out_frame_found,
  output logic [15:0]                   out_header_word,
  output logic [7:0]                    out_command_byte,
  output logic [7:0]                    out_check_byte,
  // configuration
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [irpd_pkg::PADDR_W-1:0]  paddr,
  input  logic [irpd_pkg::PDATA_W-1:0]  pwdata,
  output logic [irpd_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready
);
  import irpd_pkg::*;

  localparam int unsigned CNT_W = $clog2(PULSE_DEPTH + 1);
  localparam int unsigned IDX_W = $clog2(PULSE_DEPTH);

  // Configuration registers
  logic [TOL_W-1:0]  tol_r;
  logic [GAP_W-1:0]  gap_r;
  logic [MINP_W-1:0] minp_r;

  // Control state
  irpd_state_t         state_r, state_nxt;
  logic [TIME_W-1:0]   last_r, last_nxt;
  logic [TIME_W-1:0]   delta_r, delta_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [CNT_W-1:0]    rd_addr_r, rd_addr_nxt;
  logic                vld_r, vld_nxt;
  logic                prev_r, prev_nxt;
  logic [ENT_W-1:0]    ent_r, ent_nxt;
  logic [FRAME_W-1:0]  acc_r, acc_nxt;

  // Result register
  logic                out_valid_r, out_valid_nxt;
  logic                found_r, found_nxt;
  logic [FRAME_W-1:0]  word_r, word_nxt;

  // Pulse store
  logic [PULSE_W-1:0]  mem [PULSE_DEPTH];
  logic [PULSE_W-1:0]  rd_data_r;
  logic                mem_we;

  // Shared match unit: two comparators, targets steered by scan phase
  logic [TGT_W-1:0]    tgt_a, tgt_b;
  logic                hit_a, hit_b;
  logic [FRAME_W-1:0]  acc_shift;
  logic                cfg_wr;

  assign tgt_a = (state_r == ST_HDR) ? HDR_MARK_US  : BIT_MARK_US;
  assign tgt_b = (state_r == ST_HDR) ? HDR_SPACE_US : BIT1_SPACE_US;
  assign hit_a = near_fn(rd_data_r, tgt_a, tol_r);
  assign hit_b = near_fn(rd_data_r, tgt_b, tol_r);
  // A space that matches both bit values decodes as a one
  assign acc_shift = {acc_r[FRAME_W-2:0], hit_b};

  always_comb begin
    state_nxt     = state_r;
    last_nxt      = last_r;
    delta_nxt     = delta_r;
    cnt_nxt       = cnt_r;
    rd_addr_nxt   = rd_addr_r;
    vld_nxt       = 1'b0;
    prev_nxt      = prev_r;
    ent_nxt       = ent_r;
    acc_nxt       = acc_r;
    out_valid_nxt = 1'b0;
    found_nxt     = found_r;
    word_nxt      = word_r;
    mem_we        = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          if (!in_req_type) begin
            // Interval modulo 2^32; last edge time follows every edge
            delta_nxt = in_edge_time_us - last_r;
            last_nxt  = in_edge_time_us;
            state_nxt = ST_EDGE;
          end else if (cnt_r < CNT_W'(MIN_INTERVALS)) begin
            out_valid_nxt = 1'b1;
            found_nxt     = 1'b0;
            word_nxt      = '0;
          end else begin
            rd_addr_nxt = '0;
            prev_nxt    = 1'b0;
            state_nxt   = ST_HDR;
          end
        end
      end
      ST_EDGE: begin
        // Drop the store on a long gap, drop glitches, append otherwise while room is left
        if (delta_r > {{(TIME_W - GAP_W){1'b0}}, gap_r}) begin
          cnt_nxt = '0;
        end else if (delta_r >= {{(TIME_W - MINP_W){1'b0}}, minp_r} &&
                     cnt_r < CNT_W'(PULSE_DEPTH)) begin
          mem_we  = 1'b1;
          cnt_nxt = cnt_r + 1'b1;
        end
        state_nxt = ST_IDLE;
      end
      ST_HDR, ST_BITS: begin
        // Stream the next held interval into the read register
        if (rd_addr_r < cnt_r) begin
          vld_nxt     = 1'b1;
          rd_addr_nxt = rd_addr_r + 1'b1;
        end
        if (vld_r) begin
          if (state_r == ST_HDR) begin
            prev_nxt = hit_a;
            if (prev_r && hit_b) begin
              state_nxt = ST_BITS;
              ent_nxt   = '0;
              acc_nxt   = '0;
            end
          end else begin
            ent_nxt = ent_r + 1'b1;
            if (!ent_r[0]) begin
              if (!hit_a) begin
                out_valid_nxt = 1'b1;
                found_nxt     = 1'b0;
                word_nxt      = '0;
                state_nxt     = ST_IDLE;
              end
            end else if (!hit_a && !hit_b) begin
              out_valid_nxt = 1'b1;
              found_nxt     = 1'b0;
              word_nxt      = '0;
              state_nxt     = ST_IDLE;
            end else begin
              acc_nxt = acc_shift;
              if (ent_r == ENT_W'(2 * FRAME_BITS - 1)) begin
                out_valid_nxt = 1'b1;
                found_nxt     = 1'b1;
                word_nxt      = acc_shift;
                cnt_nxt       = '0;
                state_nxt     = ST_IDLE;
              end
            end
          end
        end else if (rd_addr_r >= cnt_r) begin
          // Ran out of held intervals
          out_valid_nxt = 1'b1;
          found_nxt     = 1'b0;
          word_nxt      = '0;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      last_r      <= '0;
      cnt_r       <= '0;
      vld_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      last_r      <= last_nxt;
      cnt_r       <= cnt_nxt;
      vld_r       <= vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath registers, no reset needed
  always_ff @(posedge clk) begin
    delta_r   <= delta_nxt;
    rd_addr_r <= rd_addr_nxt;
    prev_r    <= prev_nxt;
    ent_r     <= ent_nxt;
    acc_r     <= acc_nxt;
    found_r   <= found_nxt;
    word_r    <= word_nxt;
  end

  // Pulse store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[cnt_r[IDX_W-1:0]] <= delta_r[PULSE_W-1:0];
    end
    rd_data_r <= mem[rd_addr_r[IDX_W-1:0]];
  end

  // Configuration port
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r  <= TOL_RST;
      gap_r  <= GAP_RST;
      minp_r <= MINP_RST;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_TOL:  tol_r  <= pwdata[TOL_W-1:0];
        REG_GAP:  gap_r  <= pwdata[GAP_W-1:0];
        REG_MINP: minp_r <= pwdata[MINP_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_TOL:  prdata = {{(PDATA_W - TOL_W){1'b0}}, tol_r};
      REG_GAP:  prdata = {{(PDATA_W - GAP_W){1'b0}}, gap_r};
      REG_MINP: prdata = {{(PDATA_W - MINP_W){1'b0}}, minp_r};
      default:  prdata = '0;
    endcase
  end

  assign pready = 1'b1;

  // Outputs
  assign busy             = (state_r != ST_IDLE);
  assign out_valid        = out_valid_r;
  assign out_frame_found  = found_r;
  assign out_header_word  = word_r[31:16];
  assign out_command_byte = word_r[15:8] & 8'(BYTE_MASK);
  assign out_check_byte   = word_r[7:0] & 8'(BYTE_MASK);

  // Assertions
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(PULSE_DEPTH))
    else $error("pulse count beyond store depth");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_frame_found |->
      out_header_word == 16'd0 && out_command_byte == 8'd0 && out_check_byte == 8'd0)
    else $error("failed poll carries nonzero frame fields");

  a_ok_clears: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_frame_found |-> cnt_r == '0)
    else $error("decoded frame left the pulse store populated");

  a_scan_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_req_type && cnt_r >= CNT_W'(MIN_INTERVALS) |=> busy && !out_valid)
    else $error("poll with enough intervals did not start a scan");

endmodule
